### hdl/vic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vic_pkg: shared types and constants for vertex index compaction
// Opcodes, field widths and the 64-bit population count used by the
// compaction counter.
// ----------------------------------------------------------------------------
package vic_pkg;

  // Field widths of the input and result beats.
  localparam int OpW       = 2;
  localparam int IdxW      = 10;
  localparam int WordBits  = 64;
  localparam int BitSelW   = 6;
  localparam int PcntW     = 7;
  // Number of bitmap words that a 10-bit vertex index can reach.
  localparam int IdxWords  = 1 << (IdxW - BitSelW);

  // Input opcodes; the remaining code is ignored.
  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_MARK  = 2'd1,
    OP_QUERY = 2'd2
  } vic_op_e;

  // Number of set bits in one bitmap word.
  function automatic logic [PcntW-1:0] vic_popcount(input logic [WordBits-1:0] w);
    logic [PcntW-1:0] n;
    n = '0;
    for (int i = 0; i < WordBits; i++) begin
      n = n + PcntW'(w[i]);
    end
    return n;
  endfunction

endpackage

### hdl/vic_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vic_in_if / vic_out_if: valid-ready channels of the compaction block
// The input channel carries an opcode and a vertex index; the result
// channel carries the compacted index and the used flag.
// ----------------------------------------------------------------------------
interface vic_in_if import vic_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  opcode;
  logic [IdxW-1:0] vertex_index;

  modport source (output valid, output opcode, output vertex_index, input ready);
  modport sink   (input valid, input opcode, input vertex_index, output ready);
endinterface

interface vic_out_if import vic_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] new_index;
  logic            was_used;

  modport source (output valid, output new_index, output was_used, input ready);
  modport sink   (input valid, input new_index, input was_used, output ready);
endinterface

### hdl/vic_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vic_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vic_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/vertex_index_compaction_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_index_compaction_top: used-vertex bitmap with compacted index query
// Keeps one bit per vertex slot. Clear empties the map, mark sets one bit,
// query returns the number of marked vertices below an index and its bit.
//
//   channel | dir | beat contents                 | when
//   in_i    | in  | opcode, vertex_index          | valid && ready
//   out_o   | out | new_index, was_used           | valid && ready, query only
//
// Clear completes on acceptance. Mark reads the bitmap word and then writes it
// back. A query holds the input through the accepting cycle, a step for each
// bitmap word up to the indexed one (the last word if the index lies past the
// map), each read and counted by the single popcount accumulator, and a last
// step that loads the output register once the previous result is taken.
// Reset and clear drop the per-word valid bits, so the map reads as empty at
// once. A stalled result beat holds up the next query and all input after it.
// ----------------------------------------------------------------------------
module vertex_index_compaction_top import vic_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  vic_in_if.sink   in_i,
  vic_out_if.source out_o
);

  localparam int MapWordsFull = (MAX_POINTS + WordBits - 1) / WordBits;
  localparam int RamWords     = (MapWordsFull < IdxWords) ? MapWordsFull : IdxWords;
  localparam int AW           = (RamWords > 1) ? $clog2(RamWords) : 1;
  localparam int CntW         = IdxW + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MARK  = 4'b0010,
    ST_QUERY = 4'b0100,
    ST_DONE  = 4'b1000
  } vic_state_e;

  vic_state_e state_q, state_d;

  logic [RamWords-1:0] vld_q, vld_d;
  logic [AW-1:0]       w_q, w_d;
  logic [AW-1:0]       last_q, last_d;
  logic [BitSelW-1:0]  bit_q, bit_d;
  logic                part_q, part_d;
  logic                in_map_q, in_map_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                used_q, used_d;

  logic                out_valid_q, out_valid_d;
  logic [IdxW-1:0]     out_idx_q, out_idx_d;
  logic                out_used_q, out_used_d;

  logic                    in_acc;
  logic [IdxW-BitSelW-1:0] in_word;
  logic                    in_word_ok;
  logic                    in_in_map;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [WordBits-1:0] ram_wdata;
  logic [WordBits-1:0] ram_rdata;

  logic [WordBits-1:0] cur_word;
  logic [WordBits-1:0] below_mask;
  logic                at_last;

  // Bitmap storage.
  vic_ram #(
    .WIDTH (WordBits),
    .DEPTH (RamWords),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (w_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Input decode.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_word    = in_i.vertex_index[IdxW-1:BitSelW];
  assign in_word_ok = (32'(in_word) < RamWords);
  assign in_in_map  = (32'(in_i.vertex_index) < MAX_POINTS);

  // Current word as seen through its valid bit, and the mask below the index.
  assign cur_word   = vld_q[w_q] ? ram_rdata : '0;
  assign at_last    = (w_q == last_q);
  assign below_mask = (part_q && at_last) ? ((WordBits'(1) << bit_q) - WordBits'(1))
                                          : '1;
  assign ram_wdata  = cur_word | (WordBits'(1) << bit_q);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    vld_d     = vld_q;
    w_d       = w_q;
    last_d    = last_q;
    bit_d     = bit_q;
    part_d    = part_q;
    in_map_d  = in_map_q;
    cnt_d     = cnt_q;
    used_d    = used_q;
    ram_we    = 1'b0;
    ram_raddr = '0;

    out_valid_d = out_valid_q && !out_o.ready;
    out_idx_d   = out_idx_q;
    out_used_d  = out_used_q;

    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = (in_i.opcode == OP_MARK) ? AW'(in_word) : '0;
        if (in_acc) begin
          bit_d    = in_i.vertex_index[BitSelW-1:0];
          in_map_d = in_in_map;
          unique case (in_i.opcode)
            OP_CLEAR: begin
              vld_d = '0;
            end
            OP_MARK: begin
              if (in_in_map) begin
                w_d     = AW'(in_word);
                state_d = ST_MARK;
              end
            end
            OP_QUERY: begin
              w_d     = '0;
              cnt_d   = '0;
              used_d  = 1'b0;
              part_d  = in_word_ok;
              last_d  = in_word_ok ? AW'(in_word) : AW'(RamWords - 1);
              state_d = ST_QUERY;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MARK: begin
        ram_we     = 1'b1;
        vld_d[w_q] = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_QUERY: begin
        ram_raddr = w_q + AW'(1);
        cnt_d     = cnt_q + CntW'(vic_popcount(cur_word & below_mask));
        if (at_last) begin
          used_d  = in_map_q && cur_word[bit_q];
          state_d = ST_DONE;
        end else begin
          w_d = w_q + AW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_idx_d   = cnt_q[IdxW-1:0];
          out_used_d  = used_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    last_q     <= last_d;
    bit_q      <= bit_d;
    part_q     <= part_d;
    in_map_q   <= in_map_d;
    cnt_q      <= cnt_d;
    used_q     <= used_d;
    out_idx_q  <= out_idx_d;
    out_used_q <= out_used_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.new_index = out_idx_q;
  assign out_o.was_used  = out_used_q;

endmodule

### sim/tb_vertex_index_compaction_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_index_compaction_top: self-checking bench for index compaction
// Drives clear, mark and query beats into the used-vertex bitmap and checks
// each query result against a local bitmap and prefix count, or against the
// value typed into a pinned row. A short table covers the corner cases, then
// random sessions mark clusters of vertices and query around them. Both
// channels idle at random, and a long result hold-off backs up the input.
// ----------------------------------------------------------------------------
module tb_vertex_index_compaction_top;
  import vic_pkg::*;

  localparam int MaxPoints   = 1024;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 40;

  // The opcode that the block has to ignore.
  localparam logic [OpW-1:0] OpReserved = 2'd3;

  typedef struct packed {
    logic [IdxW-1:0] new_index;
    logic            was_used;
  } compaction_t;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [IdxW-1:0] idx;
    bit              pinned;
    logic [IdxW-1:0] want_index;
    logic            want_used;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  vic_in_if  in_if ();
  vic_out_if out_if ();

  vertex_index_compaction_top #(.MAX_POINTS(MaxPoints)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Local copy of the bitmap and the queue of query results still due.
  bit [MaxPoints-1:0] used_bits;
  compaction_t        pending_results[$];

  int mismatches      = 0;
  int results_checked = 0;
  int beats_sent      = 0;
  int clears_sent     = 0;
  int marks_sent      = 0;
  int queries_sent    = 0;
  int ignored_sent    = 0;
  int deepest_index   = 0;
  int tx_idle_pct     = 0;
  int rx_idle_pct     = 0;
  bit hold_req        = 1'b0;

  // Corner cases; rows with pinned set carry their result typed in.
  stim_row_t directed_rows [0:22] = '{
    '{OP_QUERY,   10'd0,    1'b1, 10'd0, 1'b0},  // empty map after reset
    '{OP_QUERY,   10'd1023, 1'b1, 10'd0, 1'b0},
    '{OpReserved, 10'd1023, 1'b0, 10'd0, 1'b0},  // unknown opcode, no effect
    '{OP_MARK,    10'd0,    1'b0, 10'd0, 1'b0},
    '{OP_MARK,    10'd1023, 1'b0, 10'd0, 1'b0},
    '{OP_QUERY,   10'd0,    1'b1, 10'd0, 1'b1},
    '{OP_QUERY,   10'd1023, 1'b1, 10'd1, 1'b1},
    '{OP_QUERY,   10'd1,    1'b1, 10'd1, 1'b0},  // unmarked vertex
    '{OP_MARK,    10'd63,   1'b0, 10'd0, 1'b0},  // last bit of the first word
    '{OP_MARK,    10'd64,   1'b0, 10'd0, 1'b0},  // first bit of the second word
    '{OP_MARK,    10'd64,   1'b0, 10'd0, 1'b0},  // marking twice changes nothing
    '{OP_QUERY,   10'd64,   1'b0, 10'd0, 1'b0},
    '{OP_QUERY,   10'd65,   1'b0, 10'd0, 1'b0},
    '{OP_QUERY,   10'd512,  1'b0, 10'd0, 1'b0},
    '{OpReserved, 10'd5,    1'b0, 10'd0, 1'b0},
    '{OP_QUERY,   10'd1023, 1'b0, 10'd0, 1'b0},
    '{OP_CLEAR,   10'd0,    1'b0, 10'd0, 1'b0},
    '{OP_QUERY,   10'd1023, 1'b1, 10'd0, 1'b0},
    '{OP_MARK,    10'd682,  1'b0, 10'd0, 1'b0},
    '{OP_MARK,    10'd341,  1'b0, 10'd0, 1'b0},
    '{OP_QUERY,   10'd682,  1'b0, 10'd0, 1'b0},
    '{OP_CLEAR,   10'd1023, 1'b0, 10'd0, 1'b0},  // clear ignores the index
    '{OP_QUERY,   10'd682,  1'b1, 10'd0, 1'b0}
  };

  // Compacted index: number of marked vertices strictly below the index.
  function automatic compaction_t compacted_index_of(input logic [IdxW-1:0] idx);
    compaction_t r;
    int unsigned cnt;
    cnt = 0;
    for (int i = 0; i < int'(idx); i++) begin
      cnt += used_bits[i];
    end
    r.new_index = IdxW'(cnt);
    r.was_used  = used_bits[idx];
    return r;
  endfunction

  // Query targets cluster around recent marks, word boundaries and the ends of the range, with some at random.
  function automatic logic [IdxW-1:0] pick_query_index(input logic [IdxW-1:0] recent);
    case ($urandom_range(0, 6))
      0: return recent;
      1: return recent + 1'b1;
      2: return IdxW'($urandom_range(0, IdxWords - 1) * WordBits);
      3: return IdxW'($urandom_range(0, IdxWords - 1) * WordBits + WordBits - 1);
      4: return $urandom_range(0, 1) ? {IdxW{1'b0}} : {IdxW{1'b1}};
      default: return IdxW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // Offers one beat, waits for it to be taken and updates the local bitmap.
  task automatic send_beat(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx,
                           input bit pinned = 1'b0,
                           input logic [IdxW-1:0] pinned_index = '0,
                           input logic pinned_used = 1'b0);
    compaction_t want;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.vertex_index <= idx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    case (op)
      OP_CLEAR: begin
        used_bits = '0;
        clears_sent++;
      end
      OP_MARK: begin
        used_bits[idx] = 1'b1;
        marks_sent++;
      end
      OP_QUERY: begin
        want = pinned ? compaction_t'({pinned_index, pinned_used}) : compacted_index_of(idx);
        pending_results.insert(pending_results.size(), want);
        if (int'(want.new_index) > deepest_index) deepest_index = int'(want.new_index);
        queries_sent++;
      end
      default: ignored_sent++;
    endcase
    if (op != OpReserved) beats_sent++;
  endtask

  // Random sessions until the given number of counted beats has gone in.
  task automatic run_random(input int target, input bit idling);
    int stop_at;
    int n_marks;
    int n_queries;
    int n_noise;
    int span;
    int base;
    int r;
    logic [IdxW-1:0] recent;
    stop_at = beats_sent + target;
    while (beats_sent < stop_at) begin
      tx_idle_pct = (idling && $urandom_range(0, 3) != 0) ? 10 : 0;
      rx_idle_pct = (idling && $urandom_range(0, 3) != 0) ? 6 : 0;
      if ($urandom_range(0, 9) < 7) begin
        // Well-formed session: maybe a clear, a cluster of marks, then queries.
        if ($urandom_range(0, 1)) send_beat(OP_CLEAR, IdxW'($urandom));
        n_marks = $urandom_range(1, 24);
        case ($urandom_range(0, 2))
          0: span = 8;
          1: span = WordBits;
          default: span = MaxPoints;
        endcase
        base = $urandom_range(0, MaxPoints - 1);
        for (int m = 0; m < n_marks; m++) begin
          recent = IdxW'(base + $urandom_range(0, span - 1));
          send_beat(OP_MARK, recent);
          if ($urandom_range(0, 3) == 0) send_beat(OP_QUERY, pick_query_index(recent));
        end
        n_queries = $urandom_range(2, 6);
        for (int q = 0; q < n_queries; q++) begin
          send_beat(OP_QUERY, pick_query_index(recent));
        end
      end else begin
        // Noise: any opcode, the ignored one included, at any index.
        n_noise = $urandom_range(4, 12);
        for (int k = 0; k < n_noise; k++) begin
          r = $urandom_range(0, 15);
          if (r == 0) begin
            send_beat(OP_CLEAR, IdxW'($urandom));
          end else if (r < 4) begin
            send_beat(OpReserved, IdxW'($urandom));
          end else if (r < 10) begin
            send_beat(OP_MARK, IdxW'($urandom));
          end else begin
            send_beat(OP_QUERY, IdxW'($urandom));
          end
        end
      end
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Each result beat is compared with the oldest outstanding query.
  always @(posedge clk_i) begin : check_results
    compaction_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no query outstanding, new_index",
                        int'(out_if.new_index), -1);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_if.new_index !== want.new_index) begin
          report_mismatch("new_index", int'(out_if.new_index), int'(want.new_index));
        end
        if (out_if.was_used !== want.was_used) begin
          report_mismatch("was_used", int'(out_if.was_used), int'(want.was_used));
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no beat accepted for %0d cycles", StallLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence.
  initial begin
    in_if.valid        = 1'b0;
    in_if.opcode       = OP_CLEAR;
    in_if.vertex_index = '0;
    used_bits          = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases with light idling.
    tx_idle_pct = 15;
    rx_idle_pct = 5;
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].pinned,
                directed_rows[i].want_index, directed_rows[i].want_used);
    end

    run_random(250, 1'b1);

    // Hold the result side off while queries keep coming, so the input backs up.
    tx_idle_pct = 0;
    hold_req    = 1'b1;
    for (int q = 0; q < 24; q++) begin
      send_beat((q % 6 == 5) ? OP_MARK : OP_QUERY, IdxW'($urandom));
    end

    // Sender pauses until every query has answered.
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);

    run_random(200, 1'b1);
    run_random(120, 1'b0);

    // Drain, then watch for stray result beats.
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d beats: %0d clears, %0d marks, %0d queries, %0d unknown opcodes.",
             beats_sent + ignored_sent, clears_sent, marks_sent, queries_sent, ignored_sent);
    $display("Checked %0d results, largest compacted index %0d, %0d mismatches.",
             results_checked, deepest_index, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
